/* rtl/core/idbg_pkg.sv */
// shared types and constants for the interval double-booking guard
// no dependencies
package idbg_pkg;

    localparam int TIME_W = 32;
    localparam int USED_W = 7;
    localparam int SINGLE_DEPTH_DEF = 64;
    localparam int DOUBLE_DEPTH_DEF = 64;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRIPLE = 2'd1;
    localparam logic [1:0] ST_S_FULL = 2'd2;
    localparam logic [1:0] ST_D_FULL = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } t_req;

    typedef struct packed {
        logic              accepted;
        logic [1:0]        status;
        logic [USED_W-1:0] single_used;
        logic [USED_W-1:0] double_used;
    } t_rsp;

    typedef struct packed {
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
    } t_ivl;

    typedef struct packed {
        logic rotate;
        logic push;
    } t_chain_ctl;

endpackage

/* rtl/core/interval_double_booking_guard.sv */
// interval double-booking guard top level: sequencer and two interval rings
// depends on idbg_pkg, idbg_chain, idbg_cell
//
//  channel   dir  handshake                  payload
//  request   in   i_req_valid / o_req_ready  i_req  (start_time, end_time)
//  response  out  o_rsp_valid / i_rsp_ready  o_rsp  (accepted, status, used counts)
//
// one item at a time: a scan over both rings, then a merge pass over the single
// ring and a store into it when admitted, then a handoff to the response register
// while scanning, and for the single ring while merging, each ring rotates one
// cell a cycle past its own compare point at its head
// reset clears the counts and the sequencer; ring contents need no reset
// a response waiting on i_rsp_ready holds the sequencer before its next result
module interval_double_booking_guard #(
    parameter int SINGLE_DEPTH = idbg_pkg::SINGLE_DEPTH_DEF,
    parameter int DOUBLE_DEPTH = idbg_pkg::DOUBLE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  idbg_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output idbg_pkg::t_rsp o_rsp
);
    import idbg_pkg::*;

    localparam int MAXD = (SINGLE_DEPTH > DOUBLE_DEPTH) ? SINGLE_DEPTH : DOUBLE_DEPTH;
    localparam int SCW = $clog2(SINGLE_DEPTH + 1);
    localparam int DCW = $clog2(DOUBLE_DEPTH + 1);
    localparam int STW = $clog2(MAXD + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]     r_state;
    logic [STW-1:0] r_step;
    logic [SCW-1:0] r_scnt;
    logic [DCW-1:0] r_dcnt;
    logic [SCW-1:0] r_hits;
    logic           r_triple;
    logic [1:0]     r_status;
    t_req           r_req;
    logic           r_rsp_valid;
    t_rsp           r_rsp;

    t_chain_ctl s_ctl;
    t_chain_ctl d_ctl;
    t_ivl       s_head;
    t_ivl       d_head;
    t_ivl       s_push;
    t_ivl       d_push;

    logic s_meet;
    logic d_meet;
    logic s_live;
    logic d_live;
    logic scan_last;
    logic merge_last;
    logic out_free;

    assign s_meet = (r_req.start_time < s_head.e) && (r_req.end_time > s_head.s);
    assign d_meet = (r_req.start_time < d_head.e) && (r_req.end_time > d_head.s);
    assign s_live = 32'(r_step) < 32'(r_scnt);
    assign d_live = 32'(r_step) < 32'(r_dcnt);
    assign scan_last  = 32'(r_step) == 32'(MAXD - 1);
    assign merge_last = 32'(r_step) == 32'(SINGLE_DEPTH - 1);
    assign out_free   = !r_rsp_valid || i_rsp_ready;

    assign s_push.s = r_req.start_time;
    assign s_push.e = r_req.end_time;
    assign d_push.s = (r_req.start_time > s_head.s) ? r_req.start_time : s_head.s;
    assign d_push.e = (r_req.end_time < s_head.e) ? r_req.end_time : s_head.e;

    always_comb begin
        s_ctl = '0;
        d_ctl = '0;
        case (r_state)
            S_SCAN: begin
                s_ctl.rotate = 32'(r_step) < 32'(SINGLE_DEPTH);
                d_ctl.rotate = 32'(r_step) < 32'(DOUBLE_DEPTH);
            end
            S_MERGE: begin
                s_ctl.rotate = 1'b1;
                d_ctl.push   = s_live && s_meet;
            end
            S_STORE: begin
                s_ctl.push = 1'b1;
            end
            default: begin
            end
        endcase
    end

    idbg_chain #(.DEPTH(SINGLE_DEPTH)) u_single (
        .i_clk  (i_clk),
        .i_ctl  (s_ctl),
        .i_push (s_push),
        .o_head (s_head)
    );

    idbg_chain #(.DEPTH(DOUBLE_DEPTH)) u_double (
        .i_clk  (i_clk),
        .i_ctl  (d_ctl),
        .i_push (d_push),
        .o_head (d_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_scnt      <= '0;
            r_dcnt      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state  <= S_SCAN;
                        r_step   <= '0;
                        r_req    <= i_req;
                        r_hits   <= '0;
                        r_triple <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (d_live && d_meet) begin
                        r_triple <= 1'b1;
                    end
                    if (s_live && s_meet) begin
                        r_hits <= r_hits + 1'b1;
                    end
                    r_step <= r_step + 1'b1;
                    if (scan_last) begin
                        r_step <= '0;
                        r_state <= S_DONE;
                        if (r_triple || (d_live && d_meet)) begin
                            r_status <= ST_TRIPLE;
                        end else if (32'(r_scnt) >= 32'(SINGLE_DEPTH)) begin
                            r_status <= ST_S_FULL;
                        end else if (32'(r_hits) + 32'(s_live && s_meet)
                                     > 32'(DOUBLE_DEPTH) - 32'(r_dcnt)) begin
                            r_status <= ST_D_FULL;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_MERGE;
                        end
                    end
                end
                S_MERGE: begin
                    if (s_live && s_meet) begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                    r_step <= r_step + 1'b1;
                    if (merge_last) begin
                        r_step  <= '0;
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_scnt  <= r_scnt + 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_rsp.accepted    <= r_status == ST_OK;
            r_rsp.status      <= r_status;
            r_rsp.single_used <= USED_W'(r_scnt);
            r_rsp.double_used <= USED_W'(r_dcnt);
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_scnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_scnt) <= 32'(SINGLE_DEPTH))
        else $error("admitted count exceeds depth");

    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_dcnt) <= 32'(DOUBLE_DEPTH))
        else $error("overlap count exceeds depth");

    a_acc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.accepted == (o_rsp.status == ST_OK)))
        else $error("accepted flag disagrees with status");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STORE |=> r_scnt == $past(r_scnt) + 1'b1)
        else $error("store did not grow admitted count");

    a_scnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_IDLE) |=> $stable(r_scnt) || !i_rst_n)
        else $error("admitted count changed outside store");
endmodule

/* rtl/core/idbg_cell.sv */
// one storage cell of an interval ring
// depends on idbg_pkg
module idbg_cell (
    input  logic                i_clk,
    input  idbg_pkg::t_chain_ctl i_ctl,
    input  idbg_pkg::t_ivl      i_nxt,
    input  idbg_pkg::t_ivl      i_prv,
    output idbg_pkg::t_ivl      o_q
);
    import idbg_pkg::*;

    t_ivl r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_q <= i_nxt;
        end else if (i_ctl.push) begin
            r_q <= i_prv;
        end
    end

    assign o_q = r_q;
endmodule

/* rtl/core/idbg_chain.sv */
// ring of interval cells: rotate toward the head, or push in at the head
// depends on idbg_pkg and idbg_cell
module idbg_chain #(
    parameter int DEPTH = idbg_pkg::SINGLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  idbg_pkg::t_chain_ctl i_ctl,
    input  idbg_pkg::t_ivl      i_push,
    output idbg_pkg::t_ivl      o_head
);
    import idbg_pkg::*;

    t_ivl q [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_ivl prv;
        if (k == 0) begin : g_first
            assign prv = i_push;
        end else begin : g_rest
            assign prv = q[k-1];
        end
        idbg_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (i_ctl),
            .i_nxt (q[(k + 1) % DEPTH]),
            .i_prv (prv),
            .o_q   (q[k])
        );
    end

    assign o_head = q[0];
endmodule
